>>> hw/rtl/pipm_pkg.sv
`timescale 1ns / 1ps

package pipm_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int TOL_W       = 8;
	localparam int WIN_W       = 16;
	localparam int REFS_LO_W   = 64;
	localparam int REFS_HI_W   = 32;
	localparam int REFS_W      = REFS_LO_W + REFS_HI_W;
	localparam int REF_W       = 8;
	localparam int REF_SLOTS   = 12;
	localparam int LEN_W       = 4;
	localparam int PERIOD_W    = 16;
	localparam int PROGRESS_W  = 4;

	// register indexes on the config port
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TOLERANCE      = 3'd0,
		REG_ACCEPT_MIN     = 3'd1,
		REG_ACCEPT_MAX     = 3'd2,
		REG_REFS_FIRST     = 3'd3,
		REG_REFS_LAST      = 3'd4,
		REG_PATTERN_LENGTH = 3'd5
	} pipm_reg_e_t;

	localparam logic [TOL_W-1:0]     TOLERANCE_RST  = 8'd4;
	localparam logic [WIN_W-1:0]     ACCEPT_MIN_RST = 16'd16;
	localparam logic [WIN_W-1:0]     ACCEPT_MAX_RST = 16'd43;
	localparam logic [REFS_LO_W-1:0] REFS_LO_RST    = 64'd1449346665962872093;
	localparam logic [REFS_HI_W-1:0] REFS_HI_RST    = 32'd488447271;
	localparam logic [LEN_W-1:0]     LENGTH_RST     = 4'd12;

	// edge detector -> matcher
	typedef struct packed {
		logic                edge_seen;
		logic                in_window;
		logic [REF_W-1:0]    period_low;
		logic [PERIOD_W-1:0] captured;
	} pipm_edge_t;

endpackage

>>> hw/rtl/pipm_if.sv
`timescale 1ns / 1ps

interface pipm_in_if;
	logic valid;
	logic ready;
	logic pin_level;

	modport source (output valid, output pin_level, input ready);
	modport sink   (input valid, input pin_level, output ready);
endinterface

interface pipm_out_if;
	logic        valid;
	logic        ready;
	logic        edge_seen;
	logic [15:0] captured_period;
	logic [3:0]  progress;
	logic        alarm;

	modport source (output valid, output edge_seen, output captured_period,
		output progress, output alarm, input ready);
	modport sink   (input valid, input edge_seen, input captured_period,
		input progress, input alarm, output ready);
endinterface

>>> hw/rtl/pulse_interval_pattern_matcher.sv
`timescale 1ns / 1ps
// Pulse-interval pattern matcher.
// in_ch : one beat per timer tick, payload pin_level (conditioned pin).
// out_ch: exactly one beat per input beat: edge_seen, captured_period,
//         progress (references matched so far) and alarm (pattern complete).
// Config: cfg_we/cfg_index/cfg_data write port, no read-back. Index 0
//         tolerance, 1 accept_min, 2 accept_max, 3 refs 0..7, 4 refs 8..11,
//         5 pattern_length. Write only while the block is idle.
// Output: a result appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while out_ch.ready is high; edge detect,
//         window and reference compare and index update all sit between the
//         input handshake and the result register.
// Stall: the result register holds while out_ch.ready is low; in_ch.ready
//         follows out_ch.ready whenever a result is pending, so a new tick
//         is still taken in the same cycle the pending one drains.
// Reset: counter, previous level and progress clear; registers return to
//         their defaults (tolerance 4, window 16..43, length 12). A high
//         level on the first tick counts as a rising edge.
module pulse_interval_pattern_matcher #(
	parameter int MAX_PATTERN  = 12,
	parameter int COUNTER_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	pipm_in_if.sink                          in_ch,
	pipm_out_if.source                       out_ch,
	input  logic                             cfg_we,
	input  logic [pipm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pipm_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import pipm_pkg::*;

	// config registers
	logic [TOL_W-1:0]     tolerance_q;
	logic [WIN_W-1:0]     accept_min_q;
	logic [WIN_W-1:0]     accept_max_q;
	logic [REFS_LO_W-1:0] refs_lo_q;
	logic [REFS_HI_W-1:0] refs_hi_q;
	logic [LEN_W-1:0]     length_q;

	// result register
	logic                  out_valid_q;
	logic                  edge_seen_q;
	logic [PERIOD_W-1:0]   period_q;
	logic [PROGRESS_W-1:0] progress_q;
	logic                  alarm_q;

	logic                  in_ready;
	logic                  advance;
	pipm_edge_t            edge_info;
	logic [PROGRESS_W-1:0] progress_nx;
	logic                  alarm_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q  <= TOLERANCE_RST;
			accept_min_q <= ACCEPT_MIN_RST;
			accept_max_q <= ACCEPT_MAX_RST;
			refs_lo_q    <= REFS_LO_RST;
			refs_hi_q    <= REFS_HI_RST;
			length_q     <= LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TOLERANCE:      tolerance_q  <= cfg_data[TOL_W-1:0];
				REG_ACCEPT_MIN:     accept_min_q <= cfg_data[WIN_W-1:0];
				REG_ACCEPT_MAX:     accept_max_q <= cfg_data[WIN_W-1:0];
				REG_REFS_FIRST:     refs_lo_q    <= cfg_data[REFS_LO_W-1:0];
				REG_REFS_LAST:      refs_hi_q    <= cfg_data[REFS_HI_W-1:0];
				REG_PATTERN_LENGTH: length_q     <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// take a tick whenever the result slot is empty or draining this cycle
	assign in_ready    = ~out_valid_q | out_ch.ready;
	assign in_ch.ready = in_ready;
	assign advance     = in_ch.valid & in_ready;

	pipm_period #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_period (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.pin_level  (in_ch.pin_level),
		.accept_min (accept_min_q),
		.accept_max (accept_max_q),
		.edge_info  (edge_info)
	);

	pipm_match #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_match (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.edge_info      (edge_info),
		.tolerance      (tolerance_q),
		.refs           ({refs_hi_q, refs_lo_q}),
		.pattern_length (length_q),
		.progress       (progress_nx),
		.alarm          (alarm_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload: no reset needed
	always_ff @(posedge clk) begin
		if (advance) begin
			edge_seen_q <= edge_info.edge_seen;
			period_q    <= edge_info.captured;
			progress_q  <= progress_nx;
			alarm_q     <= alarm_nx;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.edge_seen       = edge_seen_q;
	assign out_ch.captured_period = period_q;
	assign out_ch.progress        = progress_q;
	assign out_ch.alarm           = alarm_q;

endmodule

>>> hw/rtl/pipm_period.sv
`timescale 1ns / 1ps

module pipm_period #(
	parameter int COUNTER_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic                         pin_level,
	input  logic [pipm_pkg::WIN_W-1:0]   accept_min,
	input  logic [pipm_pkg::WIN_W-1:0]   accept_max,
	output pipm_pkg::pipm_edge_t         edge_info
);
	import pipm_pkg::*;

	localparam int CMP_W = (COUNTER_BITS > WIN_W) ? COUNTER_BITS : WIN_W;

	logic [COUNTER_BITS-1:0] cnt_q;
	logic                    prev_q;
	logic [COUNTER_BITS-1:0] cnt_inc;
	logic [CMP_W-1:0]        cnt_ext;
	logic                    rise;

	assign cnt_inc = cnt_q + COUNTER_BITS'(1);
	assign cnt_ext = CMP_W'(cnt_inc);
	assign rise    = pin_level & ~prev_q;

	always_comb begin
		edge_info.edge_seen  = rise;
		edge_info.in_window  = (cnt_ext >= CMP_W'(accept_min)) &&
			(cnt_ext <= CMP_W'(accept_max));
		edge_info.period_low = cnt_ext[REF_W-1:0];
		edge_info.captured   = rise ? cnt_ext[PERIOD_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			prev_q <= 1'b0;
		end else if (advance) begin
			prev_q <= pin_level;
			cnt_q  <= rise ? '0 : cnt_inc;
		end
	end

endmodule

>>> hw/rtl/pipm_match.sv
`timescale 1ns / 1ps

module pipm_match #(
	parameter int MAX_PATTERN = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           advance,
	input  pipm_pkg::pipm_edge_t           edge_info,
	input  logic [pipm_pkg::TOL_W-1:0]     tolerance,
	input  logic [pipm_pkg::REFS_W-1:0]    refs,
	input  logic [pipm_pkg::LEN_W-1:0]     pattern_length,
	output logic [pipm_pkg::PROGRESS_W-1:0] progress,
	output logic                           alarm
);
	import pipm_pkg::*;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

	logic [PROGRESS_W-1:0] idx_q;
	logic [PROGRESS_W-1:0] idx_inc;
	logic [LEN_W-1:0]      eff_len;
	logic [REF_W-1:0]      ref_val;
	logic signed [9:0]     lo_bound;
	logic signed [9:0]     hi_bound;
	logic signed [9:0]     val_s;
	logic                  hit;

	always_comb begin
		if (pattern_length == '0) begin
			eff_len = LEN_W'(1);
		end else if (pattern_length > MAX_LEN) begin
			eff_len = MAX_LEN;
		end else begin
			eff_len = pattern_length;
		end
	end

	// index stays below the effective length, which is at most MAX_PATTERN
	always_comb begin
		if (idx_q < PROGRESS_W'(REF_SLOTS)) begin
			ref_val = refs[idx_q*REF_W +: REF_W];
		end else begin
			ref_val = '0;
		end
	end

	assign lo_bound = $signed({2'b00, ref_val}) - $signed({2'b00, tolerance});
	assign hi_bound = $signed({2'b00, ref_val}) + $signed({2'b00, tolerance});
	assign val_s    = $signed({2'b00, edge_info.period_low});
	assign hit      = (val_s >= lo_bound) && (val_s <= hi_bound);
	assign idx_inc  = idx_q + PROGRESS_W'(1);

	always_comb begin
		progress = idx_q;
		alarm    = 1'b0;
		if (edge_info.edge_seen) begin
			if (!edge_info.in_window || !hit) begin
				progress = '0;
			end else if (idx_inc >= eff_len) begin
				progress = '0;
				alarm    = 1'b1;
			end else begin
				progress = idx_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (advance) begin
			idx_q <= progress;
		end
	end

endmodule

>>> hw/rtl/pipm_checker.sv
`timescale 1ns / 1ps

module pipm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        edge_seen,
	input logic [15:0] captured_period,
	input logic [3:0]  progress,
	input logic        alarm
);

	// an empty result slot never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result slot");

	// completing the pattern restarts progress and needs an edge
	a_alarm_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && alarm) |-> (edge_seen && progress == 4'd0))
		else $error("alarm without edge or restart");

	a_no_edge_no_period: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !edge_seen) |-> (captured_period == 16'd0))
		else $error("period reported without an edge");

	a_progress_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (progress <= 4'd11))
		else $error("progress out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(progress) &&
		$stable(alarm) && $stable(edge_seen) && $stable(captured_period)))
		else $error("result changed under stall");

endmodule

bind pulse_interval_pattern_matcher pipm_checker u_pipm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (in_ch.ready),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.edge_seen       (out_ch.edge_seen),
	.captured_period (out_ch.captured_period),
	.progress        (out_ch.progress),
	.alarm           (out_ch.alarm)
);
